/* sv/sorted_key_table_core_assert.svh */
// Assertion macros for the sorted key table.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SKT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");

// Next-cycle implication, checked out of reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");

`endif

/* sv/skt_pkg.sv */
// Shared constants and types for the sorted key table.
// No dependencies; the interfaces and modules refer to it by scoped names.
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 32;
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    apply;
        logic    do_insert;
        logic    do_remove;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic hit;
        logic full;
    } t_dp_sts;

endpackage

/* sv/skt_if.sv */
// Request and response channel interfaces for the sorted key table.
// Depends on skt_pkg.
interface skt_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic signed [skt_pkg::KEY_BITS-1:0] key;
    logic [skt_pkg::HANDLE_BITS-1:0]   entry_handle;

    modport source (output valid, output op, output key, output entry_handle, input ready);
    modport sink   (input valid, input op, input key, input entry_handle, output ready);
endinterface

interface skt_rsp_if;
    logic                            valid;
    logic                            ready;
    skt_pkg::t_status                status;
    logic [skt_pkg::HANDLE_BITS-1:0] found_handle;
    logic [skt_pkg::COUNT_BITS-1:0]  entry_count;
    logic                            is_empty;

    modport source (output valid, output status, output found_handle, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input found_handle, input entry_count,
                    input is_empty, output ready);
endinterface

/* sv/sorted_key_table_core.sv */
// Sorted key table: holds up to TABLE_DEPTH entries (signed key plus handle)
// in ascending key order, with insert, remove-by-key and search-by-key. Each
// request beat yields one response beat. A request is accepted when the block
// is idle; all slots compare against its key in parallel in the accepting
// cycle and the compare results are registered at acceptance. In the apply
// state, once the output register is free, the table shifts and the response
// register loads, and the response beat is presented from that register.
// No new request is taken until the previous one has been applied. A response
// waiting on the output does not stop the next request from being accepted;
// its apply cycle waits until the output register is free, and no further
// request is taken until that apply. No clearing pass after reset.
// Depends on skt_pkg, skt_if, skt_ctrl and skt_cells.
module sorted_key_table_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);

    skt_pkg::t_dp_cmd cmd;
    skt_pkg::t_dp_sts sts;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    skt_cells u_cells (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_req.op),
        .i_key          (i_req.key),
        .i_entry_handle (i_req.entry_handle),
        .o_status       (o_rsp.status),
        .o_found_handle (o_rsp.found_handle),
        .o_entry_count  (o_rsp.entry_count),
        .o_is_empty     (o_rsp.is_empty)
    );

endmodule

/* sv/skt_ctrl.sv */
// Sequencer for the sorted key table: accepts a request beat, then applies it.
// Depends on skt_pkg and sorted_key_table_core_assert.svh.
`include "sorted_key_table_core_assert.svh"

module skt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  skt_pkg::t_dp_sts i_sts,
    output skt_pkg::t_dp_cmd o_cmd
);

    skt_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_rsp_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (i_req_valid) n_state = skt_pkg::S_APPLY;
            end
            skt_pkg::S_APPLY: begin
                if (out_free) n_state = skt_pkg::S_IDLE;
            end
            default: n_state = skt_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_req_ready     = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.apply     = 1'b0;
        o_cmd.do_insert = 1'b0;
        o_cmd.do_remove = 1'b0;
        o_cmd.status    = skt_pkg::STS_DONE;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            skt_pkg::S_APPLY: begin
                o_cmd.apply = out_free;
                unique case (i_sts.op)
                    skt_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.status = skt_pkg::STS_FULL;
                        end else begin
                            o_cmd.do_insert = out_free;
                        end
                    end
                    skt_pkg::OP_REMOVE: begin
                        if (i_sts.hit) begin
                            o_cmd.do_remove = out_free;
                        end else begin
                            o_cmd.status = skt_pkg::STS_NOT_FOUND;
                        end
                    end
                    skt_pkg::OP_SEARCH: begin
                        if (!i_sts.hit) o_cmd.status = skt_pkg::STS_NOT_FOUND;
                    end
                    default: o_cmd.status = skt_pkg::STS_DONE;
                endcase
            end
            default: o_req_ready = 1'b0;
        endcase
    end

    // Response valid: set on apply, drop once the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    `SKT_ASSERT_IMPL(a_apply_needs_free_out, o_cmd.apply, !r_out_valid || i_rsp_ready)
    `SKT_ASSERT_NEXT(a_apply_gives_beat, o_cmd.apply, o_rsp_valid)
    `SKT_ASSERT_IMPL(a_insert_not_full, o_cmd.do_insert, !i_sts.full && o_cmd.apply)
    `SKT_ASSERT_IMPL(a_remove_on_hit, o_cmd.do_remove, i_sts.hit && !o_cmd.do_insert)
    `SKT_ASSERT_NEXT(a_capture_then_apply, o_cmd.capture, r_state == skt_pkg::S_APPLY)

endmodule

/* sv/skt_cells.sv */
// Datapath of the sorted key table: a row of key/handle slots that compare
// in parallel and shift on insert or remove, plus count and response registers.
// Depends on skt_pkg.
module skt_cells (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skt_pkg::t_dp_cmd                  i_cmd,
    output skt_pkg::t_dp_sts                  o_sts,
    input  logic [1:0]                        i_op,
    input  logic signed [skt_pkg::KEY_BITS-1:0] i_key,
    input  logic [skt_pkg::HANDLE_BITS-1:0]   i_entry_handle,
    output skt_pkg::t_status                  o_status,
    output logic [skt_pkg::HANDLE_BITS-1:0]   o_found_handle,
    output logic [skt_pkg::COUNT_BITS-1:0]    o_entry_count,
    output logic                              o_is_empty
);

    localparam int D  = skt_pkg::TABLE_DEPTH;
    localparam int KB = skt_pkg::KEY_BITS;
    localparam int HB = skt_pkg::HANDLE_BITS;
    localparam int CB = skt_pkg::COUNT_BITS;

    logic signed [KB-1:0] r_key [D];
    logic        [HB-1:0] r_hdl [D];
    logic signed [KB-1:0] n_key [D];
    logic        [HB-1:0] n_hdl [D];

    logic [CB-1:0]        r_count, n_count;
    logic [D-1:0]         r_ge, n_ge;
    logic [D-1:0]         r_eq, n_eq;
    logic [D-1:0]         boundary;
    skt_pkg::t_op         r_op;
    logic signed [KB-1:0] r_in_key;
    logic [HB-1:0]        r_in_hdl;
    skt_pkg::t_status     r_status;
    logic [HB-1:0]        r_found;
    logic [HB-1:0]        sel_hdl;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_slot
            logic                 occupied;
            logic signed [KB-1:0] prev_key, next_key;
            logic        [HB-1:0] prev_hdl, next_hdl;

            // Compare the incoming key against this slot; free slots count as >=
            assign occupied = CB'(g) < r_count;
            assign n_ge[g]  = !occupied || (i_key <= r_key[g]);
            assign n_eq[g]  = occupied && (i_key == r_key[g]);

            // Neighbour sources for the shifts
            if (g == 0) begin : g_first
                assign prev_key    = r_in_key;
                assign prev_hdl    = r_in_hdl;
                assign boundary[g] = r_ge[g];
            end else begin : g_mid
                assign prev_key    = r_key[g-1];
                assign prev_hdl    = r_hdl[g-1];
                assign boundary[g] = r_ge[g] && !r_ge[g-1];
            end
            if (g == D - 1) begin : g_last
                assign next_key = r_key[g];
                assign next_hdl = r_hdl[g];
            end else begin : g_inner
                assign next_key = r_key[g+1];
                assign next_hdl = r_hdl[g+1];
            end

            // Insert at the boundary and shift up behind it; remove shifts down
            always_comb begin
                priority if (i_cmd.do_insert && boundary[g]) begin
                    n_key[g] = r_in_key;
                    n_hdl[g] = r_in_hdl;
                end else if (i_cmd.do_insert && r_ge[g]) begin
                    n_key[g] = prev_key;
                    n_hdl[g] = prev_hdl;
                end else if (i_cmd.do_remove && r_ge[g]) begin
                    n_key[g] = next_key;
                    n_hdl[g] = next_hdl;
                end else begin
                    n_key[g] = r_key[g];
                    n_hdl[g] = r_hdl[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.apply) begin
                    r_key[g] <= n_key[g];
                    r_hdl[g] <= n_hdl[g];
                end
            end
        end
    endgenerate

    // Hold the request beat and the compare vectors
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ge     <= n_ge;
            r_eq     <= n_eq;
            r_op     <= skt_pkg::t_op'(i_op);
            r_in_key <= i_key;
            r_in_hdl <= i_entry_handle;
        end
    end

    // Pick the handle at the first slot not below the key
    always_comb begin
        sel_hdl = '0;
        for (int i = 0; i < D; i++) begin
            sel_hdl = sel_hdl | (boundary[i] ? r_hdl[i] : '0);
        end
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CB'(1);
        end else if (i_cmd.do_remove) begin
            n_count = r_count - CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status <= i_cmd.status;
            r_found  <= (r_op == skt_pkg::OP_SEARCH && o_sts.hit) ? sel_hdl : '0;
        end
    end

    assign o_sts.op   = r_op;
    assign o_sts.hit  = |r_eq;
    assign o_sts.full = r_count == CB'(D);

    assign o_status       = r_status;
    assign o_found_handle = r_found;
    assign o_entry_count  = r_count;
    assign o_is_empty     = r_count == '0;

endmodule
